/* rtl/core/wbg_pkg.sv */
// ----------------------------------------------------------------------------
// wbg_pkg
// Shared types and Q8.8 geometry constants for the wind-barb glyph generator.
// ----------------------------------------------------------------------------
`default_nettype none

package wbg_pkg;

  // Field widths
  localparam int SPEED_W = 12;
  localparam int X_W     = 13;
  localparam int Y_W     = 15;
  localparam int KNOTS_W = 9;   // rounded speed never exceeds 256
  localparam int CNT_W   = 3;   // flags <= 5, long barbs <= 4
  localparam int IDX_W   = 3;   // command index inside one shape (dot has 5)

  // Saturation limit in knots
  localparam int MAX_KNOTS = 255;

  // Path kinds and drawing ops
  localparam logic PATH_FILL   = 1'b0;
  localparam logic PATH_STROKE = 1'b1;
  localparam logic OP_MOVE     = 1'b0;
  localparam logic OP_LINE     = 1'b1;

  // Q8.8 geometry, x side
  localparam logic signed [X_W-1:0] SPOT_X      = 13'sd358;
  localparam logic signed [X_W-1:0] BARB_X      = 13'sd2172;
  localparam logic signed [X_W-1:0] HALF_BARB_X = 13'sd1086;
  localparam logic signed [X_W-1:0] ZERO_X      = 13'sd0;

  // Q8.8 geometry, y side
  localparam logic signed [Y_W-1:0] SPOT_Y      = 15'sd358;
  localparam logic signed [Y_W-1:0] FLAG_Y      = 15'sd1792;
  localparam logic signed [Y_W-1:0] INTERVAL_Y  = 15'sd922;
  localparam logic signed [Y_W-1:0] BARB_Y      = 15'sd2172;
  localparam logic signed [Y_W-1:0] HALF_BARB_Y = 15'sd1086;
  localparam logic signed [Y_W-1:0] LONE_Y_OFS  = 15'sd1382;
  localparam logic signed [Y_W-1:0] ZERO_Y      = 15'sd0;
  // top of the bare stem: spot + stem length
  localparam logic signed [Y_W-1:0] BASE_Y      = 15'sd358 + 15'sd4608;
  // lone short barb position
  localparam logic signed [Y_W-1:0] LONE_Y      = BASE_Y - LONE_Y_OFS;
  // flag tip offset relative to flag top: barb - flag
  localparam logic signed [Y_W-1:0] FLAG_TIP_Y  = BARB_Y - FLAG_Y;

  // Divisor choice for the shared subtract/compare unit
  typedef enum logic [1:0] {
    DIV_50,
    DIV_10,
    DIV_5
  } div_sel_t;

  // Result of one subtract/compare step
  typedef struct packed {
    logic               ge;    // operand >= divisor
    logic [KNOTS_W-1:0] diff;  // operand - divisor
  } step_res_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_FLAG,
    ST_DIV_LONG,
    ST_DIV_SHORT,
    ST_DOT,
    ST_FLAG,
    ST_STEM,
    ST_LONG,
    ST_SHORT
  } state_t;

endpackage

`default_nettype wire

/* rtl/core/wbg_in_if.sv */
// ----------------------------------------------------------------------------
// wbg_in_if
// Speed request channel: valid/ready with the speed sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbg_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] speed_q4;
  logic        speed_missing;

  modport source (output valid, output speed_q4, output speed_missing, input ready);
  modport sink   (input valid, input speed_q4, input speed_missing, output ready);
endinterface

`default_nettype wire

/* rtl/core/wbg_out_if.sv */
// ----------------------------------------------------------------------------
// wbg_out_if
// Path command channel: valid/ready with one move/line command.
// ----------------------------------------------------------------------------
`default_nettype none

interface wbg_out_if;
  logic               valid;
  logic               ready;
  logic               path_kind;
  logic               op;
  logic signed [12:0] x_q8;
  logic signed [14:0] y_q8;
  logic               last;

  modport source (output valid, output path_kind, output op, output x_q8,
                  output y_q8, output last, input ready);
  modport sink   (input valid, input path_kind, input op, input x_q8,
                  input y_q8, input last, output ready);
endinterface

`default_nettype wire

/* rtl/core/wbg_step_unit.sv */
// ----------------------------------------------------------------------------
// wbg_step_unit
// Shared subtract/compare unit used for the repeated-subtraction split of
// the speed into flags (50), long barbs (10) and short barbs (5).
// ----------------------------------------------------------------------------
`default_nettype none

module wbg_step_unit
  import wbg_pkg::*;
(
  input  wire logic [KNOTS_W-1:0] operand,
  input  wire div_sel_t           div_sel,
  output step_res_t               res
);

  logic [KNOTS_W-1:0] divisor;
  logic [KNOTS_W:0]   wide_diff;

  // divisor select
  always_comb begin
    case (div_sel)
      DIV_50:  divisor = KNOTS_W'(50);
      DIV_10:  divisor = KNOTS_W'(10);
      DIV_5:   divisor = KNOTS_W'(5);
      default: divisor = KNOTS_W'(5);
    endcase
  end

  // one subtract; borrow out gives the compare
  assign wide_diff = {1'b0, operand} - {1'b0, divisor};
  assign res.ge    = ~wide_diff[KNOTS_W];
  assign res.diff  = wide_diff[KNOTS_W-1:0];

endmodule

`default_nettype wire

/* rtl/core/wind_barb_glyph_generator.sv */
// ----------------------------------------------------------------------------
// wind_barb_glyph_generator
// Turns one wind speed sample into the move/line commands of a wind barb.
// ----------------------------------------------------------------------------
// Usage:
//   speed channel: one request carries speed_q4 (knots, 4 fractional bits)
//   and speed_missing. A missing sample is taken and produces no command.
//   cmd channel: one request per path command (kind, op, Q8.8 x/y, last).
//   last marks the final command of a speed sample.
// Sequence:
//   After a request is taken, the shared subtract unit splits the rounded
//   speed into flags, long barbs and a short barb. Then commands leave at
//   one per cycle while cmd is not stalled: 5 for the dot, 4 per flag, 2 for
//   the stem, 2 per barb, at most 33. A saturated input gives 29 commands.
//   speed.ready is high only while the sequencer is idle; a missing sample
//   leaves the sequencer idle.
// Reset (rst, synchronous): sequencer returns to idle and the output
//   register is emptied.
// Back-pressure: a stalled cmd holds the output register and the sequencer
//   waits; no command is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none

module wind_barb_glyph_generator
  import wbg_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  wbg_in_if.sink    speed,
  wbg_out_if.source cmd
);

  state_t state, state_next;

  // split results and counters
  logic [KNOTS_W-1:0]    rem, rem_next;
  logic [CNT_W-1:0]      flags, flags_next;
  logic [CNT_W-1:0]      longs, longs_next;
  logic                  shorts, shorts_next;
  logic                  stroke, stroke_next;
  logic [CNT_W-1:0]      cnt, cnt_next;
  logic [IDX_W-1:0]      idx, idx_next;
  logic signed [Y_W-1:0] ytop, ytop_next;
  logic signed [Y_W-1:0] y, y_next;

  // output register
  logic                  cmd_valid;
  logic                  cmd_kind;
  logic                  cmd_op;
  logic signed [X_W-1:0] cmd_x;
  logic signed [Y_W-1:0] cmd_y;
  logic                  cmd_last;

  // command being produced this cycle
  logic                  emit_c;
  logic                  kind_c;
  logic                  op_c;
  logic signed [X_W-1:0] x_c;
  logic signed [Y_W-1:0] y_c;
  logic                  last_c;

  logic                  adv;
  logic                  take;
  logic [SPEED_W:0]      speed_rnd;
  logic [KNOTS_W-1:0]    knots;
  logic [KNOTS_W-1:0]    knots_sat;
  logic                  lone;
  logic                  flag_end;
  logic                  long_end;

  div_sel_t  div_sel;
  step_res_t step;

  // handshakes
  assign speed.ready = (state == ST_IDLE);
  assign take        = speed.valid && speed.ready;
  assign adv         = !cmd_valid || cmd.ready;

  // round half up, then saturate
  assign speed_rnd = {1'b0, speed.speed_q4} + (SPEED_W+1)'(8);
  assign knots     = speed_rnd[SPEED_W:4];
  assign knots_sat = (10'(knots) > 10'(MAX_KNOTS)) ? KNOTS_W'(MAX_KNOTS) : knots;

  assign lone     = (longs == '0) && (flags == '0) && shorts;
  assign flag_end = (cnt == flags - CNT_W'(1));
  assign long_end = (cnt == longs - CNT_W'(1));

  // divisor follows the split phase
  always_comb begin
    case (state)
      ST_DIV_FLAG: div_sel = DIV_50;
      ST_DIV_LONG: div_sel = DIV_10;
      default:     div_sel = DIV_5;
    endcase
  end

  wbg_step_unit u_step (
    .operand (rem),
    .div_sel (div_sel),
    .res     (step)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (take && !speed.speed_missing) state_next = ST_DIV_FLAG;
      end
      ST_DIV_FLAG: begin
        if (!step.ge) state_next = ST_DIV_LONG;
      end
      ST_DIV_LONG: begin
        if (!step.ge) state_next = ST_DIV_SHORT;
      end
      ST_DIV_SHORT: state_next = ST_DOT;
      ST_DOT: begin
        if (adv && idx == IDX_W'(4)) begin
          if (flags != '0)  state_next = ST_FLAG;
          else if (stroke)  state_next = ST_STEM;
          else              state_next = ST_IDLE;
        end
      end
      ST_FLAG: begin
        if (adv && idx == IDX_W'(3) && flag_end) begin
          state_next = stroke ? ST_STEM : ST_IDLE;
        end
      end
      ST_STEM: begin
        if (adv && idx == IDX_W'(1)) begin
          if (longs != '0)  state_next = ST_LONG;
          else if (shorts)  state_next = ST_SHORT;
          else              state_next = ST_IDLE;
        end
      end
      ST_LONG: begin
        if (adv && idx == IDX_W'(1) && long_end) begin
          state_next = shorts ? ST_SHORT : ST_IDLE;
        end
      end
      ST_SHORT: begin
        if (adv && idx == IDX_W'(1)) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath: commands and counter updates
  always_comb begin
    rem_next    = rem;
    flags_next  = flags;
    longs_next  = longs;
    shorts_next = shorts;
    stroke_next = stroke;
    cnt_next    = cnt;
    idx_next    = idx;
    ytop_next   = ytop;
    y_next      = y;
    emit_c      = 1'b0;
    kind_c      = PATH_FILL;
    op_c        = (idx != '0) ? OP_LINE : OP_MOVE;
    x_c         = ZERO_X;
    y_c         = ZERO_Y;
    last_c      = 1'b0;
    case (state)
      ST_IDLE: begin
        if (take) begin
          rem_next    = knots_sat;
          flags_next  = '0;
          longs_next  = '0;
          shorts_next = 1'b0;
          stroke_next = (knots_sat >= KNOTS_W'(5));
          cnt_next    = '0;
          idx_next    = '0;
          ytop_next   = BASE_Y;
        end
      end
      ST_DIV_FLAG: begin
        if (step.ge) begin
          rem_next   = step.diff;
          flags_next = flags + CNT_W'(1);
          // first flag also opens the gap above the stem
          ytop_next  = (flags == '0) ? ytop + FLAG_Y + INTERVAL_Y : ytop + FLAG_Y;
        end
      end
      ST_DIV_LONG: begin
        if (step.ge) begin
          rem_next   = step.diff;
          longs_next = longs + CNT_W'(1);
        end
      end
      ST_DIV_SHORT: begin
        shorts_next = step.ge;
        if (step.ge) rem_next = step.diff;
      end
      // square dot around the origin
      ST_DOT: begin
        emit_c = 1'b1;
        case (idx)
          IDX_W'(0): begin x_c =  SPOT_X; y_c =  SPOT_Y; end
          IDX_W'(1): begin x_c =  SPOT_X; y_c = -SPOT_Y; end
          IDX_W'(2): begin x_c = -SPOT_X; y_c = -SPOT_Y; end
          IDX_W'(3): begin x_c = -SPOT_X; y_c =  SPOT_Y; end
          default:   begin x_c =  SPOT_X; y_c =  SPOT_Y; end
        endcase
        last_c = (idx == IDX_W'(4)) && (flags == '0) && !stroke;
        if (adv) begin
          if (idx == IDX_W'(4)) begin
            idx_next = '0;
            cnt_next = '0;
            y_next   = ytop;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      // one triangle per 50 knots, top down
      ST_FLAG: begin
        emit_c = 1'b1;
        case (idx)
          IDX_W'(0): begin x_c = ZERO_X;  y_c = y;              end
          IDX_W'(1): begin x_c = -BARB_X; y_c = y + FLAG_TIP_Y; end
          IDX_W'(2): begin x_c = ZERO_X;  y_c = y - FLAG_Y;     end
          default:   begin x_c = ZERO_X;  y_c = y;              end
        endcase
        last_c = (idx == IDX_W'(3)) && flag_end && !stroke;
        if (adv) begin
          if (idx == IDX_W'(3)) begin
            idx_next = '0;
            y_next   = y - FLAG_Y;
            cnt_next = flag_end ? '0 : cnt + CNT_W'(1);
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      // stem from origin to the top
      ST_STEM: begin
        emit_c = 1'b1;
        kind_c = PATH_STROKE;
        y_c    = (idx == '0) ? ZERO_Y : ytop;
        last_c = (idx == IDX_W'(1)) && (longs == '0) && !shorts;
        if (adv) begin
          if (idx == IDX_W'(1)) begin
            idx_next = '0;
            cnt_next = '0;
            // barbs start right below the flags
            y_next   = lone ? LONE_Y : BASE_Y;
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      // long barb per 10 knots
      ST_LONG: begin
        emit_c = 1'b1;
        kind_c = PATH_STROKE;
        x_c    = (idx == '0) ? ZERO_X : -BARB_X;
        y_c    = (idx == '0) ? y : y + BARB_Y;
        last_c = (idx == IDX_W'(1)) && long_end && !shorts;
        if (adv) begin
          if (idx == IDX_W'(1)) begin
            idx_next = '0;
            y_next   = y - INTERVAL_Y;
            cnt_next = long_end ? '0 : cnt + CNT_W'(1);
          end else begin
            idx_next = idx + IDX_W'(1);
          end
        end
      end
      // single short barb
      ST_SHORT: begin
        emit_c = 1'b1;
        kind_c = PATH_STROKE;
        x_c    = (idx == '0) ? ZERO_X : -HALF_BARB_X;
        y_c    = (idx == '0) ? y : y + HALF_BARB_Y;
        last_c = (idx == IDX_W'(1));
        if (adv) begin
          idx_next = (idx == IDX_W'(1)) ? '0 : idx + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // sequencer and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cmd_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (adv) cmd_valid <= emit_c;
    end
  end

  // working registers and output payload
  always_ff @(posedge clk) begin
    rem    <= rem_next;
    flags  <= flags_next;
    longs  <= longs_next;
    shorts <= shorts_next;
    stroke <= stroke_next;
    cnt    <= cnt_next;
    idx    <= idx_next;
    ytop   <= ytop_next;
    y      <= y_next;
    if (adv && emit_c) begin
      cmd_kind <= kind_c;
      cmd_op   <= op_c;
      cmd_x    <= x_c;
      cmd_y    <= y_c;
      cmd_last <= last_c;
    end
  end

  assign cmd.valid     = cmd_valid;
  assign cmd.path_kind = cmd_kind;
  assign cmd.op        = cmd_op;
  assign cmd.x_q8      = cmd_x;
  assign cmd.y_q8      = cmd_y;
  assign cmd.last      = cmd_last;

  // the command that ends a glyph must carry last
  a_last_on_exit: assert property (@(posedge clk) disable iff (rst)
    (emit_c && adv && state_next == ST_IDLE) |-> last_c)
    else $error("glyph ended without last");

  // the split leaves less than one short barb and at most four long barbs
  a_split_done: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DOT) |-> (rem < KNOTS_W'(5) && longs <= CNT_W'(4)))
    else $error("speed split incomplete");

  // flag loop stays within the flag count
  a_flag_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLAG) |-> (cnt < flags))
    else $error("flag counter overrun");

  // long barb loop stays within its count
  a_long_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_LONG) |-> (cnt < longs))
    else $error("long barb counter overrun");

endmodule

`default_nettype wire

/* tb/sv/tb_wind_barb_glyph_generator.sv */
// ----------------------------------------------------------------------------
// tb_wind_barb_glyph_generator
// Self-checking bench: speed requests go in from a queue, and every path
// command coming out is checked against a glyph plotted in the bench itself.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_wind_barb_glyph_generator;
  import wbg_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Q8.8 glyph geometry
  localparam int DOT_HALF   = 358;
  localparam int STEM_LEN   = 4608;
  localparam int GAP_STEP   = 922;
  localparam int FLAG_DROP  = 1792;
  localparam int LONG_REACH = 2172;
  localparam int SHORT_REACH = 1086;
  localparam int LONE_DROP  = 1382;
  localparam int KNOT_CAP   = 255;

  localparam int RANDOM_ITEMS = 296;
  localparam int CALM_TAIL    = 40;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    logic [11:0] speed_q4;
    logic        missing;
  } speed_req_t;

  typedef struct packed {
    logic               path_kind;
    logic               op;
    logic signed [12:0] x_q8;
    logic signed [14:0] y_q8;
    logic               last;
  } path_cmd_t;

  logic clk;
  logic rst;

  wbg_in_if  speed_if ();
  wbg_out_if cmd_if ();

  wind_barb_glyph_generator i_dut (
    .clk   (clk),
    .rst   (rst),
    .speed (speed_if),
    .cmd   (cmd_if)
  );

  speed_req_t speed_reqs_q[$];
  path_cmd_t  barb_cmds_q[$];
  int         error_cnt = 0;
  int         cycle_cnt = 0;
  bit         calm = 1'b0;
  int         send_gap = 0;
  int         stall_left = 0;

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    speed_if.valid = 1'b0;
    speed_if.speed_q4 = '0;
    speed_if.speed_missing = 1'b0;
    cmd_if.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
  end

  task automatic report(input string what);
    error_cnt++;
    if (error_cnt <= PRINT_CAP) $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  function automatic void add_cmd(input logic kind, input logic op,
                                  input int x, input int y);
    path_cmd_t c;
    c.path_kind = kind;
    c.op        = op;
    c.x_q8      = x[12:0];
    c.y_q8      = y[14:0];
    c.last      = 1'b0;
    barb_cmds_q.push_back(c);
  endfunction

  // Plot the glyph of one accepted speed request into the expected queue
  function automatic void plot_barb(input speed_req_t req);
    int knots, flags, longs, shorts, rest, top, y, first;
    path_cmd_t c;
    if (req.missing) return;
    first = barb_cmds_q.size();
    knots = (int'(req.speed_q4) + 8) >> 4;
    if (knots > KNOT_CAP) knots = KNOT_CAP;
    flags  = knots / 50;
    rest   = knots - flags * 50;
    longs  = rest / 10;
    rest   = rest - longs * 10;
    shorts = rest / 5;
    top = DOT_HALF + STEM_LEN;
    if (flags > 0) top += flags * FLAG_DROP + GAP_STEP;

    // dot
    add_cmd(PATH_FILL, OP_MOVE,  DOT_HALF,  DOT_HALF);
    add_cmd(PATH_FILL, OP_LINE,  DOT_HALF, -DOT_HALF);
    add_cmd(PATH_FILL, OP_LINE, -DOT_HALF, -DOT_HALF);
    add_cmd(PATH_FILL, OP_LINE, -DOT_HALF,  DOT_HALF);
    add_cmd(PATH_FILL, OP_LINE,  DOT_HALF,  DOT_HALF);

    // flags, from the top down
    y = top;
    for (int i = 0; i < flags; i++) begin
      add_cmd(PATH_FILL, OP_MOVE, 0, y);
      add_cmd(PATH_FILL, OP_LINE, -LONG_REACH, y - FLAG_DROP + LONG_REACH);
      add_cmd(PATH_FILL, OP_LINE, 0, y - FLAG_DROP);
      add_cmd(PATH_FILL, OP_LINE, 0, y);
      y -= FLAG_DROP;
    end

    // stem and barbs
    if (knots >= 5) begin
      add_cmd(PATH_STROKE, OP_MOVE, 0, 0);
      add_cmd(PATH_STROKE, OP_LINE, 0, top);
      y = top - flags * FLAG_DROP;
      if (flags > 0) y -= GAP_STEP;
      for (int i = 0; i < longs; i++) begin
        add_cmd(PATH_STROKE, OP_MOVE, 0, y);
        add_cmd(PATH_STROKE, OP_LINE, -LONG_REACH, y + LONG_REACH);
        y -= GAP_STEP;
      end
      // a short barb standing alone sits lower on the stem
      if (longs == 0 && flags == 0 && shorts > 0) y -= LONE_DROP;
      for (int i = 0; i < shorts; i++) begin
        add_cmd(PATH_STROKE, OP_MOVE, 0, y);
        add_cmd(PATH_STROKE, OP_LINE, -SHORT_REACH, y + SHORT_REACH);
        y -= GAP_STEP;
      end
    end

    if (barb_cmds_q.size() > first) begin
      c = barb_cmds_q[$];
      c.last = 1'b1;
      barb_cmds_q[$] = c;
    end
  endfunction

  // Speed request driver
  always @(posedge clk) begin
    speed_req_t req;
    if (rst) begin
      speed_if.valid <= 1'b0;
      send_gap = 0;
    end else begin
      calm = (speed_reqs_q.size() < CALM_TAIL);
      if (speed_if.valid && !speed_if.ready) begin
        // hold the request until taken
      end else if (send_gap > 0) begin
        speed_if.valid <= 1'b0;
        send_gap--;
      end else if (speed_reqs_q.size() > 0) begin
        req = speed_reqs_q.pop_front();
        speed_if.valid         <= 1'b1;
        speed_if.speed_q4      <= req.speed_q4;
        speed_if.speed_missing <= req.missing;
        if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 15);
      end else begin
        speed_if.valid <= 1'b0;
      end
    end
  end

  // Predict on every accepted request
  always @(posedge clk) begin
    speed_req_t req;
    if (!rst && speed_if.valid && speed_if.ready) begin
      req.speed_q4 = speed_if.speed_q4;
      req.missing  = speed_if.speed_missing;
      plot_barb(req);
    end
  end

  // Command monitor with random back-pressure
  always @(posedge clk) begin
    path_cmd_t want;
    if (rst) begin
      cmd_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) begin
        if (barb_cmds_q.size() == 0) begin
          report($sformatf("unexpected command kind=%0b op=%0b x=%0d y=%0d last=%0b",
                           cmd_if.path_kind, cmd_if.op, cmd_if.x_q8, cmd_if.y_q8,
                           cmd_if.last));
        end else begin
          want = barb_cmds_q.pop_front();
          if (cmd_if.path_kind !== want.path_kind || cmd_if.op !== want.op ||
              cmd_if.x_q8 !== want.x_q8 || cmd_if.y_q8 !== want.y_q8 ||
              cmd_if.last !== want.last)
            report($sformatf("got kind=%0b op=%0b x=%0d y=%0d last=%0b, want %0b %0b %0d %0d %0b",
                             cmd_if.path_kind, cmd_if.op, cmd_if.x_q8, cmd_if.y_q8,
                             cmd_if.last, want.path_kind, want.op, want.x_q8,
                             want.y_q8, want.last));
        end
      end
      if (stall_left > 0) begin
        cmd_if.ready <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        cmd_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 14);
      end else begin
        cmd_if.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin
    int directed[$];
    int rand_cnt;
    int pick;
    speed_req_t req;

    // missing samples, both speed extremes
    req.missing = 1'b1;
    req.speed_q4 = 12'd0;    speed_reqs_q.push_back(req);
    req.speed_q4 = 12'hFFF;  speed_reqs_q.push_back(req);

    // rounding edges, barb mixes, flag counts and saturation
    directed = '{0, 1, 7, 8, 71, 72, 152, 232, 312, 712, 776, 792, 872, 952,
                 1592, 2392, 3192, 3976, 3992, 4072, 4088, 4095};
    req.missing = 1'b0;
    foreach (directed[i]) begin
      req.speed_q4 = directed[i][11:0];
      speed_reqs_q.push_back(req);
    end

    // random part: mostly real speeds, some missing, some near the extremes
    rand_cnt = 0;
    while (rand_cnt < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      req.missing = (pick == 0);
      if (pick <= 2)       req.speed_q4 = 12'($urandom_range(0, 4095));
      else if (pick <= 4)  req.speed_q4 = 12'($urandom_range(0, 120));
      else if (pick == 5)  req.speed_q4 = 12'($urandom_range(3900, 4095));
      else                 req.speed_q4 = 12'($urandom_range(0, 4095));
      rand_cnt++;
      speed_reqs_q.push_back(req);
    end

    @(negedge clk);
    while (rst) @(negedge clk);
    while (speed_reqs_q.size() != 0 || speed_if.valid) @(negedge clk);
    while (barb_cmds_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (barb_cmds_q.size() != 0) report("expected commands left over");

    if (error_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/wbg_pkg.sv
rtl/core/wbg_in_if.sv
rtl/core/wbg_out_if.sv
rtl/core/wbg_step_unit.sv
rtl/core/wind_barb_glyph_generator.sv
tb/sv/tb_wind_barb_glyph_generator.sv
